// ===== design/cac_pkg.sv =====
// ----------------------------------------------------------------------------
// cac_pkg: shared types and constants for the CAN address claim engine
// Item structs for both channels, counter and config widths, frame codes and modes.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

	localparam int unsigned CLAIM_WINDOW_TICKS_DEF = 250;
	localparam int unsigned MAX_ATTEMPTS_DEF       = 10;

	localparam int unsigned WINDOW_W  = 8;
	localparam int unsigned ATTEMPT_W = 4;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 21;

	// input operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IDENTITY  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MFR_CODE  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ECU_INST  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FUNC_INST = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FUNC_CODE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VEH_SYS   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IND_GROUP = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PREF_ADDR = 4'd7;

	// claim status codes
	localparam logic [1:0] STAT_IDLE   = 2'd0;
	localparam logic [1:0] STAT_CLAIM  = 2'd1;
	localparam logic [1:0] STAT_HELD   = 2'd2;
	localparam logic [1:0] STAT_CANNOT = 2'd3;

	localparam logic [7:0]  PF_CLAIMED    = 8'hEE;
	localparam logic [7:0]  PF_REQUEST    = 8'hEA;
	localparam logic [7:0]  ADDR_LIMIT    = 8'hFD;
	localparam logic [7:0]  ADDR_NULL     = 8'hFE;
	localparam logic [7:0]  ADDR_GLOBAL   = 8'hFF;
	localparam logic [28:0] CLAIM_ID_BASE = 29'h18EEFF00;
	localparam logic [23:0] REQ_CLAIM_PGN = 24'h00EE00;
	localparam logic [3:0]  DLC_CLAIM     = 4'd8;
	localparam logic [3:0]  DLC_REQUEST   = 4'd3;

	localparam logic [20:0] IDENTITY_RST  = 21'd0;
	localparam logic [2:0]  IND_GROUP_RST = 3'd2;
	localparam logic [7:0]  PREF_ADDR_RST = 8'd128;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_CLAIM  = 4'b0010,
		MODE_HELD   = 4'b0100,
		MODE_CANNOT = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        frame_extended;
		logic [28:0] frame_id;
		logic [3:0]  frame_dlc;
		logic [63:0] frame_data;
	} in_item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [28:0] tx_id;
		logic [63:0] tx_data;
		logic [1:0]  claim_status;
		logic [7:0]  own_address;
	} out_item_t;

endpackage : cac_pkg

`default_nettype wire

// ===== design/can_address_claim_engine.sv =====
// ----------------------------------------------------------------------------
// can_address_claim_engine: J1939 source address claim
// Packs the NAME from its registers, claims an address, yields or re-asserts
// on contending claims and answers address-claimed requests once held.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_stall  | in_item  (in_item_t)
//  out     | from block| out_valid / out_stall| out_item (out_item_t)
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Every item yields exactly one result item, through the input register and then the result register.
//  One item per cycle unless the output stalls: input register, one step of claim logic, result register.
//  cfg_ready is always high; registers take effect on the next item.
//  A stalled result holds in the result register; the input register stalls
//  behind it, so in_stall rises only when both are full.
//  Reset clears the claim state to idle and the registers to their defaults.
`default_nettype none

module can_address_claim_engine
	import cac_pkg::*;
#(
	parameter int unsigned CLAIM_WINDOW_TICKS = CLAIM_WINDOW_TICKS_DEF,
	parameter int unsigned MAX_ATTEMPTS       = MAX_ATTEMPTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [WINDOW_W-1:0]  WINDOW_INIT = WINDOW_W'(CLAIM_WINDOW_TICKS);
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = ATTEMPT_W'(MAX_ATTEMPTS);

	// configuration
	logic [20:0] identity_q;
	logic [10:0] mfr_code_q;
	logic [2:0]  ecu_inst_q;
	logic [4:0]  func_inst_q;
	logic [7:0]  func_code_q;
	logic [6:0]  veh_sys_q;
	logic [2:0]  ind_group_q;
	logic [7:0]  pref_addr_q;

	// claim state
	mode_t                mode_q;
	logic [7:0]           addr_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [ATTEMPT_W-1:0] attempt_q;

	logic     valid_s1;
	in_item_t item_s1;
	logic     out_valid_q;
	out_item_t out_item_q;

	logic advance;

	mode_t                mode_d;
	logic [7:0]           addr_d;
	logic [WINDOW_W-1:0]  window_d;
	logic [ATTEMPT_W-1:0] attempt_d;
	out_item_t            res;

	logic [63:0]          name;
	logic [7:0]           sa, pf, ps;
	logic                 active, claim_hit, req_hit;
	logic                 send;
	logic [7:0]           send_sa;
	logic [7:0]           addr_nxt;
	logic [ATTEMPT_W-1:0] attempt_nxt;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign name = {1'b1, ind_group_q, 4'd0, veh_sys_q, 1'b0, func_code_q,
		func_inst_q, ecu_inst_q, mfr_code_q, identity_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			identity_q  <= IDENTITY_RST;
			mfr_code_q  <= '0;
			ecu_inst_q  <= '0;
			func_inst_q <= '0;
			func_code_q <= '0;
			veh_sys_q   <= '0;
			ind_group_q <= IND_GROUP_RST;
			pref_addr_q <= PREF_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IDENTITY:  identity_q  <= cfg_data;
				REG_MFR_CODE:  mfr_code_q  <= cfg_data[10:0];
				REG_ECU_INST:  ecu_inst_q  <= cfg_data[2:0];
				REG_FUNC_INST: func_inst_q <= cfg_data[4:0];
				REG_FUNC_CODE: func_code_q <= cfg_data[7:0];
				REG_VEH_SYS:   veh_sys_q   <= cfg_data[6:0];
				REG_IND_GROUP: ind_group_q <= cfg_data[2:0];
				REG_PREF_ADDR: pref_addr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sa = item_s1.frame_id[7:0];
		ps = item_s1.frame_id[15:8];
		pf = item_s1.frame_id[23:16];
		active = (mode_q == MODE_CLAIM) || (mode_q == MODE_HELD);
		claim_hit = (pf == PF_CLAIMED) && (sa == addr_q) && (item_s1.frame_dlc == DLC_CLAIM);
		req_hit = (mode_q == MODE_HELD) && (pf == PF_REQUEST)
			&& ((ps == addr_q) || (ps == ADDR_GLOBAL))
			&& (item_s1.frame_dlc == DLC_REQUEST)
			&& (item_s1.frame_data[23:0] == REQ_CLAIM_PGN);
		// a loss while held counts as the first yield from the held address
		attempt_nxt = ((mode_q == MODE_HELD) ? '0 : attempt_q) + 1'b1;
		addr_nxt    = addr_q + 8'd1;

		mode_d    = mode_q;
		addr_d    = addr_q;
		window_d  = window_q;
		attempt_d = attempt_q;
		send      = 1'b0;
		send_sa   = addr_q;

		case (item_s1.op)
			OP_START: begin
				attempt_d = '0;
				addr_d    = pref_addr_q;
				send      = 1'b1;
				if (pref_addr_q >= ADDR_LIMIT) begin
					mode_d   = MODE_CANNOT;
					window_d = '0;
					send_sa  = ADDR_NULL;
				end else begin
					mode_d   = MODE_CLAIM;
					window_d = WINDOW_INIT;
					send_sa  = pref_addr_q;
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_CLAIM) begin
					if (window_q > WINDOW_W'(1)) begin
						window_d = window_q - 1'b1;
					end else begin
						window_d = '0;
						mode_d   = MODE_HELD;
					end
				end
			end
			OP_FRAME: begin
				if (item_s1.frame_extended && active) begin
					if (claim_hit) begin
						send = 1'b1;
						if (item_s1.frame_data <= name) begin
							attempt_d = attempt_nxt;
							addr_d    = addr_nxt;
							if ((addr_nxt >= ADDR_LIMIT) || (attempt_nxt >= ATTEMPT_MAX)) begin
								mode_d   = MODE_CANNOT;
								window_d = '0;
								send_sa  = ADDR_NULL;
							end else begin
								mode_d   = MODE_CLAIM;
								window_d = WINDOW_INIT;
								send_sa  = addr_nxt;
							end
						end else if (mode_q == MODE_CLAIM) begin
							window_d = WINDOW_INIT;
						end
					end else if (req_hit) begin
						send = 1'b1;
					end
				end
			end
			default: ;
		endcase

		res.tx_valid = send;
		res.tx_id    = send ? (CLAIM_ID_BASE | {21'd0, send_sa}) : '0;
		res.tx_data  = send ? name : '0;
		unique case (mode_d)
			MODE_IDLE:   res.claim_status = STAT_IDLE;
			MODE_CLAIM:  res.claim_status = STAT_CLAIM;
			MODE_HELD:   res.claim_status = STAT_HELD;
			MODE_CANNOT: res.claim_status = STAT_CANNOT;
			default:     res.claim_status = STAT_IDLE;
		endcase
		res.own_address = ((mode_d == MODE_CLAIM) || (mode_d == MODE_HELD)) ? addr_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_IDLE;
			addr_q      <= '0;
			window_q    <= '0;
			attempt_q   <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					mode_q    <= mode_d;
					addr_q    <= addr_d;
					window_q  <= window_d;
					attempt_q <= attempt_d;
				end
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
		if (advance && valid_s1) begin
			out_item_q <= res;
		end
	end

	a_window_only_claiming: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_CLAIM) |-> (window_q == '0))
		else $error("window count nonzero outside claiming");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with free pipeline");

	a_held_tx_own: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.tx_valid && out_item_q.claim_status == STAT_HELD)
		|-> (out_item_q.tx_id[7:0] == out_item_q.own_address))
		else $error("held claim sent from foreign address");

	a_cannot_null: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.tx_valid && out_item_q.claim_status == STAT_CANNOT)
		|-> (out_item_q.tx_id[7:0] == ADDR_NULL))
		else $error("cannot-claim not sent from null address");

endmodule : can_address_claim_engine

`default_nettype wire
